// ----- rtl/lrufr_pkg.sv -----
// Shared constants, codes and payload types of the LRU frame replacement list.
package lrufr_pkg;

	localparam int FRAMES     = 64;
	localparam int FRAME_BITS = 6;
	localparam int PAGE_BITS  = 16;
	localparam int OWNER_BITS = 8;
	localparam int DATA_BITS  = PAGE_BITS + OWNER_BITS;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_TOUCH  = 2'd1;
	localparam logic [1:0] KIND_EVICT  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_ABSENT  = 2'd2;
	localparam logic [1:0] ST_PRESENT = 2'd3;

	typedef struct packed {
		logic [1:0]            kind;
		logic [FRAME_BITS-1:0] frame_number;
		logic [PAGE_BITS-1:0]  page_number;
		logic [OWNER_BITS-1:0] owner_id;
	} cmd_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [FRAME_BITS-1:0] victim_frame;
		logic [PAGE_BITS-1:0]  victim_page;
		logic [OWNER_BITS-1:0] victim_owner;
	} result_t;

endpackage

// ----- rtl/lru_frame_replacement_list_core.sv -----
// Top level: LRU recency list over physical frames, sequencer and link/data RAMs.
//
//  channel  | ports               | handshake
//  ---------+---------------------+-------------------------------------------
//  command  | start, busy, cmd    | word taken at a clock edge with start & !busy
//  result   | done, result        | word shown for one cycle while done is high
//
// Insert, touch of an absent or newest frame and evict of an empty list end in
// S_EXEC, other evicts in S_FETCH. The next command may be taken in the cycle
// the result shows. The link RAMs have one write port each, so a touch that
// moves a frame unlinks it in S_FETCH and relinks it at the newest end in S_LINK.
// Reset (arst_n low) empties the list and clears all presence bits at once.
// The result side cannot stall; done is a one-cycle strobe.
module lru_frame_replacement_list_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  lrufr_pkg::cmd_t         cmd,
	output logic                    done,
	output lrufr_pkg::result_t      result
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_FETCH = 4'b0100,
		S_LINK  = 4'b1000
	} state_t;

	state_t                                 state_q;
	lrufr_pkg::cmd_t                        req_q;
	logic [lrufr_pkg::FRAMES-1:0]           present_q;
	logic [lrufr_pkg::FRAME_BITS-1:0]       newest_q;
	logic [lrufr_pkg::FRAME_BITS-1:0]       oldest_q;
	logic                                   nonempty_q;
	lrufr_pkg::result_t                     result_q;
	logic                                   done_q;

	logic [lrufr_pkg::FRAME_BITS-1:0]       raddr;
	logic                                   d_we;
	logic [lrufr_pkg::DATA_BITS-1:0]        d_rdata;
	logic                                   nw_we;
	logic [lrufr_pkg::FRAME_BITS-1:0]       nw_waddr;
	logic [lrufr_pkg::FRAME_BITS-1:0]       nw_wdata;
	logic [lrufr_pkg::FRAME_BITS-1:0]       nw_rdata;
	logic                                   od_we;
	logic [lrufr_pkg::FRAME_BITS-1:0]       od_waddr;
	logic [lrufr_pkg::FRAME_BITS-1:0]       od_wdata;
	logic [lrufr_pkg::FRAME_BITS-1:0]       od_rdata;
	logic [lrufr_pkg::FRAME_BITS-1:0]       f;

	assign f      = req_q.frame_number;
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// Read the oldest frame for evict, the requested frame for touch.
	assign raddr = (req_q.kind == lrufr_pkg::KIND_EVICT) ? oldest_q : f;

	always_comb begin
		d_we     = 1'b0;
		nw_we    = 1'b0;
		nw_waddr = newest_q;
		nw_wdata = f;
		od_we    = 1'b0;
		od_waddr = f;
		od_wdata = newest_q;
		unique case (state_q)
			S_EXEC: begin
				if (req_q.kind == lrufr_pkg::KIND_INSERT && !present_q[f]) begin
					d_we  = 1'b1;
					nw_we = nonempty_q;
					od_we = nonempty_q;
				end
			end
			S_FETCH: begin
				// unlink a middle frame: newer[o] = n, older[n] = o
				if (req_q.kind == lrufr_pkg::KIND_TOUCH && f != oldest_q) begin
					nw_we    = 1'b1;
					nw_waddr = od_rdata;
					nw_wdata = nw_rdata;
					od_we    = 1'b1;
					od_waddr = nw_rdata;
					od_wdata = od_rdata;
				end
			end
			S_LINK: begin
				nw_we = 1'b1;
				od_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	lrufr_ram #(.WIDTH(lrufr_pkg::DATA_BITS), .DEPTH(lrufr_pkg::FRAMES)) u_data_ram (
		.clk     (clk),
		.we      (d_we),
		.waddr   (f),
		.wdata   ({req_q.page_number, req_q.owner_id}),
		.raddr   (raddr),
		.rdata_q (d_rdata)
	);

	lrufr_ram #(.WIDTH(lrufr_pkg::FRAME_BITS), .DEPTH(lrufr_pkg::FRAMES)) u_newer_ram (
		.clk     (clk),
		.we      (nw_we),
		.waddr   (nw_waddr),
		.wdata   (nw_wdata),
		.raddr   (raddr),
		.rdata_q (nw_rdata)
	);

	lrufr_ram #(.WIDTH(lrufr_pkg::FRAME_BITS), .DEPTH(lrufr_pkg::FRAMES)) u_older_ram (
		.clk     (clk),
		.we      (od_we),
		.waddr   (od_waddr),
		.wdata   (od_wdata),
		.raddr   (raddr),
		.rdata_q (od_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			req_q      <= '0;
			present_q  <= '0;
			newest_q   <= '0;
			oldest_q   <= '0;
			nonempty_q <= 1'b0;
			result_q   <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= cmd;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (req_q.kind)
						lrufr_pkg::KIND_INSERT: begin
							if (present_q[f]) begin
								result_q <= '{lrufr_pkg::ST_PRESENT, '0, '0, '0};
							end else begin
								present_q[f] <= 1'b1;
								newest_q     <= f;
								if (!nonempty_q) begin
									oldest_q <= f;
								end
								nonempty_q <= 1'b1;
								result_q   <= '{lrufr_pkg::ST_OK, '0, '0, '0};
							end
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						lrufr_pkg::KIND_TOUCH: begin
							if (!present_q[f]) begin
								result_q <= '{lrufr_pkg::ST_ABSENT, '0, '0, '0};
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else if (f == newest_q) begin
								result_q <= '{lrufr_pkg::ST_OK, '0, '0, '0};
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_FETCH;
							end
						end
						lrufr_pkg::KIND_EVICT: begin
							if (!nonempty_q) begin
								result_q <= '{lrufr_pkg::ST_EMPTY, '0, '0, '0};
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_FETCH;
							end
						end
						default: begin
							result_q <= '{lrufr_pkg::ST_OK, '0, '0, '0};
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end
					endcase
				end
				S_FETCH: begin
					if (req_q.kind == lrufr_pkg::KIND_EVICT) begin
						result_q <= '{lrufr_pkg::ST_OK, oldest_q,
							d_rdata[lrufr_pkg::DATA_BITS-1:lrufr_pkg::OWNER_BITS],
							d_rdata[lrufr_pkg::OWNER_BITS-1:0]};
						present_q[oldest_q] <= 1'b0;
						if (oldest_q == newest_q) begin
							nonempty_q <= 1'b0;
						end else begin
							oldest_q <= nw_rdata;
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						// advance the oldest pointer past a moved oldest frame
						if (f == oldest_q) begin
							oldest_q <= nw_rdata;
						end
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					newest_q <= f;
					result_q <= '{lrufr_pkg::ST_OK, '0, '0, '0};
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy && $past(busy))
		else $error("result strobe outside the end of an operation");

	a_fail_zero_victim: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_q.status != lrufr_pkg::ST_OK |->
			result_q.victim_frame == '0 && result_q.victim_page == '0 &&
			result_q.victim_owner == '0)
		else $error("victim fields not zero on a failed operation");

	a_evict_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FETCH && req_q.kind == lrufr_pkg::KIND_EVICT |=>
			!present_q[$past(oldest_q)])
		else $error("evicted frame still marked present");

endmodule

// ----- rtl/lrufr_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module lrufr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

// ----- test/tb.sv -----
// Testbench for the LRU frame replacement list: directed rows, then random words.
`timescale 1ns / 100ps

module tb;
	import lrufr_pkg::*;

	localparam logic [1:0] KIND_IGNORED = 2'd3;
	localparam int STALL_LIMIT  = 200;
	localparam int PHASE_WORDS  = 200;
	localparam int MAX_GAP      = 40;

	typedef struct {
		cmd_t    c;
		bit      typed;
		result_t r;
	} row_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    done;
	result_t result;

	// recency list as the block should hold it
	bit                    lru_present [FRAMES];
	logic [PAGE_BITS-1:0]  lru_page    [FRAMES];
	logic [OWNER_BITS-1:0] lru_owner   [FRAMES];
	logic [FRAME_BITS-1:0] lru_newer   [FRAMES];
	logic [FRAME_BITS-1:0] lru_older   [FRAMES];
	logic [FRAME_BITS-1:0] lru_newest;
	logic [FRAME_BITS-1:0] lru_oldest;
	bit                    lru_nonempty;
	int                    lru_depth;

	result_t reports_due[$];
	row_t    directed_rows[$];
	bit      row_typed;
	result_t row_expect;
	int      mismatches;
	int      words_taken;
	int      status_seen [4];
	int      deepest_list;
	int      quiet_cycles;
	int      sender_idle_pct;

	lru_frame_replacement_list_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void lru_link_newest(logic [FRAME_BITS-1:0] f);
		if (lru_nonempty) begin
			lru_older[f] = lru_newest;
			lru_newer[lru_newest] = f;
			lru_newest = f;
		end else begin
			lru_newest = f;
			lru_oldest = f;
			lru_nonempty = 1'b1;
		end
	endfunction

	function automatic result_t lru_apply(cmd_t c);
		result_t               r;
		logic [FRAME_BITS-1:0] f;
		logic [FRAME_BITS-1:0] n;
		logic [FRAME_BITS-1:0] o;
		r = '0;
		f = c.frame_number;
		r.status = ST_OK;
		case (c.kind)
			KIND_INSERT: begin
				if (lru_present[f]) begin
					r.status = ST_PRESENT;
				end else begin
					lru_present[f] = 1'b1;
					lru_page[f] = c.page_number;
					lru_owner[f] = c.owner_id;
					lru_link_newest(f);
					lru_depth++;
				end
			end
			KIND_TOUCH: begin
				if (!lru_present[f]) begin
					r.status = ST_ABSENT;
				end else if (f != lru_newest) begin
					// unlink, then relink at the newest end
					n = lru_newer[f];
					if (f == lru_oldest) begin
						lru_oldest = n;
					end else begin
						o = lru_older[f];
						lru_newer[o] = n;
						lru_older[n] = o;
					end
					lru_link_newest(f);
				end
			end
			KIND_EVICT: begin
				if (!lru_nonempty) begin
					r.status = ST_EMPTY;
				end else begin
					r.victim_frame = lru_oldest;
					r.victim_page = lru_page[lru_oldest];
					r.victim_owner = lru_owner[lru_oldest];
					lru_present[lru_oldest] = 1'b0;
					lru_depth--;
					if (lru_oldest == lru_newest)
						lru_nonempty = 1'b0;
					else
						lru_oldest = lru_newer[lru_oldest];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void add_row(logic [1:0] k, logic [FRAME_BITS-1:0] f,
			logic [PAGE_BITS-1:0] p, logic [OWNER_BITS-1:0] o, bit typed,
			logic [1:0] st = ST_OK, logic [FRAME_BITS-1:0] vf = '0,
			logic [PAGE_BITS-1:0] vp = '0, logic [OWNER_BITS-1:0] vo = '0);
		row_t w;
		w.c.kind = k;
		w.c.frame_number = f;
		w.c.page_number = p;
		w.c.owner_id = o;
		w.typed = typed;
		w.r.status = st;
		w.r.victim_frame = vf;
		w.r.victim_page = vp;
		w.r.victim_owner = vo;
		directed_rows.push_back(w);
	endfunction

	// scan from a random frame for one in the wanted state
	function automatic logic [FRAME_BITS-1:0] pick_frame(bit want_present);
		int base;
		int idx;
		base = $urandom_range(FRAMES - 1);
		for (int i = 0; i < FRAMES; i++) begin
			idx = (base + i) % FRAMES;
			if (lru_present[idx] == want_present)
				return idx[FRAME_BITS-1:0];
		end
		return base[FRAME_BITS-1:0];
	endfunction

	function automatic cmd_t random_word();
		cmd_t c;
		int   roll;
		int   insert_w;
		int   evict_w;
		c.page_number = PAGE_BITS'($urandom_range(16'hffff));
		c.owner_id = OWNER_BITS'($urandom_range(8'hff));
		insert_w = (lru_depth < 8) ? 55 : (lru_depth > 48) ? 15 : 35;
		evict_w = (lru_depth > 48) ? 40 : 20;
		roll = $urandom_range(99);
		if (roll < 2) begin
			c.kind = KIND_IGNORED;
			c.frame_number = FRAME_BITS'($urandom_range(FRAMES - 1));
		end else if (roll < 2 + insert_w) begin
			c.kind = KIND_INSERT;
			c.frame_number = ($urandom_range(99) < 85) ? pick_frame(1'b0)
				: pick_frame(1'b1);
		end else if (roll < 2 + insert_w + evict_w) begin
			c.kind = KIND_EVICT;
			c.frame_number = FRAME_BITS'($urandom_range(FRAMES - 1));
		end else begin
			c.kind = KIND_TOUCH;
			c.frame_number = ($urandom_range(99) < 85) ? pick_frame(1'b1)
				: pick_frame(1'b0);
		end
		return c;
	endfunction

	// hold start until the word is taken; returns at the following falling edge
	task automatic drive_word(cmd_t c, bit typed, result_t r);
		int gap;
		gap = 0;
		// idle before the word at the phase's rate
		while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
			gap++;
		end
		row_typed = typed;
		row_expect = r;
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		result_t predicted;
		result_t want;
		if (arst_n) begin
			if (start && !busy) begin
				predicted = lru_apply(cmd);
				reports_due.push_back(row_typed ? row_expect : predicted);
				words_taken++;
				if (lru_depth > deepest_list)
					deepest_list = lru_depth;
			end
			if (done) begin
				if (reports_due.size() == 0) begin
					$display("%0t: result with nothing expected: %h", $time, result);
					mismatches++;
				end else begin
					want = reports_due.pop_front();
					check_field("status", 16'(want.status), 16'(result.status));
					check_field("victim_frame", 16'(want.victim_frame),
						16'(result.victim_frame));
					check_field("victim_page", want.victim_page, result.victim_page);
					check_field("victim_owner", 16'(want.victim_owner),
						16'(result.victim_owner));
					if (!$isunknown(result.status))
						status_seen[result.status]++;
				end
			end
		end
	end

	// stop a hung run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		int      idle_plan [4];
		int      waited;
		result_t none;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		row_typed = 1'b0;
		row_expect = '0;
		none = '0;
		mismatches = 0;
		words_taken = 0;
		deepest_list = 0;
		quiet_cycles = 0;
		sender_idle_pct = 0;
		lru_nonempty = 1'b0;
		lru_newest = '0;
		lru_oldest = '0;
		lru_depth = 0;
		for (int i = 0; i < FRAMES; i++)
			lru_present[i] = 1'b0;
		for (int i = 0; i < 4; i++)
			status_seen[i] = 0;
		idle_plan[0] = 0;
		idle_plan[1] = 85;
		idle_plan[2] = 0;
		idle_plan[3] = 30;

		add_row(KIND_EVICT, 6'd0, 16'h0000, 8'h00, 1'b1, ST_EMPTY);
		add_row(KIND_TOUCH, 6'd0, 16'h0000, 8'h00, 1'b1, ST_ABSENT);
		add_row(KIND_IGNORED, 6'd63, 16'hffff, 8'hff, 1'b1, ST_OK);
		add_row(KIND_INSERT, 6'd63, 16'hffff, 8'hff, 1'b1, ST_OK);
		add_row(KIND_INSERT, 6'd63, 16'h1234, 8'h56, 1'b1, ST_PRESENT);
		add_row(KIND_INSERT, 6'd0, 16'h0000, 8'h00, 1'b1, ST_OK);
		add_row(KIND_TOUCH, 6'd0, 16'h0000, 8'h00, 1'b1, ST_OK);
		add_row(KIND_TOUCH, 6'd63, 16'h0000, 8'h00, 1'b1, ST_OK);
		add_row(KIND_EVICT, 6'd63, 16'hffff, 8'hff, 1'b1, ST_OK, 6'd0, 16'h0000, 8'h00);
		add_row(KIND_EVICT, 6'd0, 16'h0000, 8'h00, 1'b1, ST_OK, 6'd63, 16'hffff, 8'hff);
		add_row(KIND_EVICT, 6'd0, 16'h0000, 8'h00, 1'b1, ST_EMPTY);
		add_row(KIND_INSERT, 6'd21, 16'h5555, 8'h55, 1'b0);
		add_row(KIND_INSERT, 6'd42, 16'haaaa, 8'haa, 1'b0);
		add_row(KIND_INSERT, 6'd7, 16'h0f0f, 8'h0f, 1'b0);
		add_row(KIND_TOUCH, 6'd42, 16'hffff, 8'hff, 1'b0);
		add_row(KIND_TOUCH, 6'd21, 16'h0000, 8'h00, 1'b0);
		add_row(KIND_TOUCH, 6'd63, 16'h0000, 8'h00, 1'b1, ST_ABSENT);
		add_row(KIND_INSERT, 6'd7, 16'hbeef, 8'h33, 1'b1, ST_PRESENT);
		add_row(KIND_EVICT, 6'd0, 16'h0000, 8'h00, 1'b0);
		add_row(KIND_EVICT, 6'd63, 16'hffff, 8'hff, 1'b0);
		add_row(KIND_EVICT, 6'd0, 16'h0000, 8'h00, 1'b0);
		add_row(KIND_EVICT, 6'd0, 16'h0000, 8'h00, 1'b1, ST_EMPTY);
		add_row(KIND_TOUCH, 6'd7, 16'h0000, 8'h00, 1'b1, ST_ABSENT);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			drive_word(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].r);

		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct = idle_plan[ph];
			repeat (PHASE_WORDS)
				drive_word(random_word(), 1'b0, none);
		end
		start <= 1'b0;

		waited = 0;
		while (reports_due.size() != 0 && waited < 100) begin
			@(posedge clk);
			waited++;
		end
		repeat (6) @(posedge clk);
		if (reports_due.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, reports_due.size());
			mismatches += reports_due.size();
		end

		$display("Took %0d words; list reached %0d frames deep.", words_taken, deepest_list);
		$display("Results: %0d ok, %0d empty evicts, %0d absent touches, %0d repeat inserts.",
			status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_ABSENT],
			status_seen[ST_PRESENT]);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/lrufr_pkg.sv
rtl/lrufr_ram.sv
rtl/lru_frame_replacement_list_core.sv
test/tb.sv
